// File: design/vgc_pkg.sv
// vgc_pkg: shared types and constants of the vlan gateway cam table
// command and status codes, entry layout and default depth; no dependencies
`timescale 1ns / 1ps

package vgc_pkg;

   localparam int DefaultTableDepth = 16;

   localparam int VlanW = 12;
   localparam int MacW  = 48;
   localparam int CountW = 5;

   localparam logic [VlanW-1:0] VlanMaxValid = 12'd4094;

   localparam logic [1:0] CMD_SET         = 2'd0;
   localparam logic [1:0] CMD_REMOVE      = 2'd1;
   localparam logic [1:0] CMD_LOOKUP_VLAN = 2'd2;
   localparam logic [1:0] CMD_LOOKUP_MAC  = 2'd3;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_INVALID_VLAN = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL   = 2'd2;

   typedef struct packed {
      logic [VlanW-1:0] vlan;
      logic [MacW-1:0]  mac;
   } entry_type;

endpackage

// File: design/vgc_cell.sv
// vgc_cell: one table slot in the rotating ring of entries
// depends on vgc_pkg for the entry layout
`timescale 1ns / 1ps

module vgc_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  vgc_pkg::entry_type  entry_in,
   output vgc_pkg::entry_type  entry_out
);

   vgc_pkg::entry_type entry_ff;

   // slot contents are undefined until written, so no reset here
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

// File: design/vlan_gateway_cam_table.sv
// vlan_gateway_cam_table: vlan to gateway mac table built as a ring of vgc_cell slots
// depends on vgc_pkg and vgc_cell
//
//   channel   ports                                         handshake
//   request   req_command, req_vlan_id, req_mac_in          start high while busy low
//   response  rsp_status, rsp_found, rsp_mac_out,           rsp_valid high for one cycle
//             rsp_entry_count, rsp_active
//
// the ring rotates one slot per cycle while scanning or filling; a full turn visits every
// entry at the head cell and leaves the ring in place again.
// set, lookups and remove of an absent vlan make one turn (scan); remove of a present
// vlan makes a second turn (fill) to move the last entry into the freed slot; the
// response follows in the done state. an invalid vlan on set or remove skips the scan.
// reset clears the entry count and control only. the response cannot be stalled;
// busy stays high until the cycle after rsp_valid.
`timescale 1ns / 1ps

module vlan_gateway_cam_table #(
   parameter int TABLE_DEPTH = vgc_pkg::DefaultTableDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_command,
   input  logic [vgc_pkg::VlanW-1:0]   req_vlan_id,
   input  logic [vgc_pkg::MacW-1:0]    req_mac_in,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_found,
   output logic [vgc_pkg::MacW-1:0]    rsp_mac_out,
   output logic [vgc_pkg::CountW-1:0]  rsp_entry_count,
   output logic                        rsp_active
);

   localparam int PosW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW = $clog2(TABLE_DEPTH + 1);
   localparam logic [PosW-1:0] PosLast = PosW'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FILL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]                 cmd_ff;
   logic [vgc_pkg::VlanW-1:0]  vid_ff;
   logic [vgc_pkg::MacW-1:0]   mac_ff;
   logic [PosW-1:0]            pos_ff, pos_in;
   logic [CntW-1:0]            count_ff, count_in;
   logic                       hit_ff, hit_in;
   logic                       appended_ff, appended_in;
   logic [PosW-1:0]            slot_ff, slot_in;
   vgc_pkg::entry_type         last_ff, last_in;
   logic [1:0]                 status_ff, status_in;
   logic                       found_ff, found_in;
   logic [vgc_pkg::MacW-1:0]   mac_res_ff, mac_res_in;

   vgc_pkg::entry_type         ring [TABLE_DEPTH];
   vgc_pkg::entry_type         head;
   vgc_pkg::entry_type         feedback;
   logic                       shift_en;

   logic                       accept;
   logic                       vid_ok;
   logic                       head_valid;
   logic                       vlan_match;
   logic                       mac_match;
   logic [CntW-1:0]            pos_ext;
   logic [CntW-1:0]            last_pos;

   // ring of slots: cell k loads from cell k+1, the tail loads the (edited) head
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      vgc_pkg::entry_type cell_in;
      if (k == TABLE_DEPTH - 1) begin : g_tail
         assign cell_in = feedback;
      end else begin : g_body
         assign cell_in = ring[k+1];
      end
      vgc_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .entry_in  (cell_in),
         .entry_out (ring[k])
      );
   end

   assign head     = ring[0];
   assign accept   = start && !busy;
   assign vid_ok   = (req_vlan_id != '0) && (req_vlan_id <= vgc_pkg::VlanMaxValid);
   assign shift_en = (state_ff == ST_SCAN) || (state_ff == ST_FILL);

   assign pos_ext    = CntW'(pos_ff);
   assign last_pos   = count_ff - CntW'(1);
   assign head_valid = pos_ext < count_ff;
   assign vlan_match = head_valid && (head.vlan == vid_ff);
   assign mac_match  = head_valid && (head.mac == mac_ff);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      hit_in      = hit_ff;
      appended_in = appended_ff;
      slot_in     = slot_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      mac_res_in  = mac_res_ff;
      feedback    = head;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in      = '0;
               hit_in      = 1'b0;
               appended_in = 1'b0;
               status_in   = vgc_pkg::STATUS_OK;
               found_in    = 1'b0;
               mac_res_in  = '0;
               if (!vid_ok && (req_command == vgc_pkg::CMD_SET ||
                               req_command == vgc_pkg::CMD_REMOVE)) begin
                  status_in = vgc_pkg::STATUS_INVALID_VLAN;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            pos_in = pos_ff + PosW'(1);
            case (cmd_ff)
               vgc_pkg::CMD_SET: begin
                  if (vlan_match) begin
                     feedback.mac = mac_ff;
                     hit_in       = 1'b1;
                  end else if (pos_ext == count_ff && !hit_ff) begin
                     // first free slot and no match seen: append here
                     feedback.vlan = vid_ff;
                     feedback.mac  = mac_ff;
                     appended_in   = 1'b1;
                  end
               end
               vgc_pkg::CMD_REMOVE: begin
                  if (vlan_match) begin
                     hit_in  = 1'b1;
                     slot_in = pos_ff;
                  end
                  if (pos_ext == last_pos) begin
                     last_in = head;
                  end
               end
               vgc_pkg::CMD_LOOKUP_VLAN: begin
                  if (vlan_match) begin
                     found_in   = 1'b1;
                     mac_res_in = head.mac;
                  end
               end
               default: begin
                  if (mac_match) begin
                     found_in = 1'b1;
                  end
               end
            endcase

            if (pos_ff == PosLast) begin
               pos_in   = '0;
               state_in = ST_DONE;
               if (cmd_ff == vgc_pkg::CMD_SET) begin
                  if (appended_in) begin
                     count_in = count_ff + CntW'(1);
                  end else if (!hit_in) begin
                     status_in = vgc_pkg::STATUS_TABLE_FULL;
                  end
               end else if (cmd_ff == vgc_pkg::CMD_REMOVE && hit_in) begin
                  state_in = ST_FILL;
               end
            end
         end

         ST_FILL: begin
            pos_in = pos_ff + PosW'(1);
            if (pos_ff == slot_ff) begin
               feedback = last_ff;
            end
            if (pos_ff == PosLast) begin
               pos_in   = '0;
               count_in = last_pos;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         vid_ff <= req_vlan_id;
         mac_ff <= req_mac_in;
      end
      hit_ff      <= hit_in;
      appended_ff <= appended_in;
      slot_ff     <= slot_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      mac_res_ff  <= mac_res_in;
   end

   // count register is narrower or wider than the port depending on depth
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_mac_out     = mac_res_ff;
   assign rsp_entry_count = vgc_pkg::CountW'(count_ff);
   assign rsp_active      = (count_ff != '0);

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for vlan_gateway_cam_table
// keeps its own copy of the vlan/mac table and checks every response; needs vgc_pkg
`timescale 1ns / 1ps

module testbench;

   localparam int Depth         = vgc_pkg::DefaultTableDepth;
   localparam int MaxGap        = 40;
   localparam int WatchdogLimit = 1000;

   typedef struct packed {
      logic [1:0]                 status;
      logic                       found;
      logic [vgc_pkg::MacW-1:0]   mac;
      logic [vgc_pkg::CountW-1:0] count;
      logic                       active;
   } answer_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic [1:0]                 req_command = vgc_pkg::CMD_SET;
   logic [vgc_pkg::VlanW-1:0]  req_vlan_id = '0;
   logic [vgc_pkg::MacW-1:0]   req_mac_in = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [1:0]                 rsp_status;
   logic                       rsp_found;
   logic [vgc_pkg::MacW-1:0]   rsp_mac_out;
   logic [vgc_pkg::CountW-1:0] rsp_entry_count;
   logic                       rsp_active;

   vgc_pkg::entry_type gateway_table[Depth];
   int unsigned        gateway_count = 0;
   answer_type         pending_answers[$];

   int sender_idle_pct = 0;
   int requests_sent   = 0;
   int answers_checked = 0;
   int full_rejects    = 0;
   int lookup_hits     = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;

   vlan_gateway_cam_table #(.TABLE_DEPTH(Depth)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_vlan_id     (req_vlan_id),
      .req_mac_in      (req_mac_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_mac_out     (rsp_mac_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_active      (rsp_active)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // applies one request to the table copy and returns the response it should give
   function automatic answer_type apply_table_command(logic [1:0] cmd,
                                                      logic [vgc_pkg::VlanW-1:0] vid,
                                                      logic [vgc_pkg::MacW-1:0] mac);
      answer_type ans;
      int         hit;
      logic       vid_ok;
      ans = '0;
      hit = -1;
      vid_ok = (vid != '0) && (vid <= vgc_pkg::VlanMaxValid);
      for (int k = 0; k < gateway_count; k++)
         if (hit < 0 && gateway_table[k].vlan == vid) hit = k;
      case (cmd)
         vgc_pkg::CMD_SET: begin
            if (!vid_ok) ans.status = vgc_pkg::STATUS_INVALID_VLAN;
            else if (hit >= 0) gateway_table[hit].mac = mac;
            else if (gateway_count < Depth) begin
               gateway_table[gateway_count] = '{vlan: vid, mac: mac};
               gateway_count++;
            end else ans.status = vgc_pkg::STATUS_TABLE_FULL;
         end
         vgc_pkg::CMD_REMOVE: begin
            if (!vid_ok) ans.status = vgc_pkg::STATUS_INVALID_VLAN;
            else if (hit >= 0) begin
               // last entry fills the freed slot
               gateway_table[hit] = gateway_table[gateway_count - 1];
               gateway_count--;
            end
         end
         vgc_pkg::CMD_LOOKUP_VLAN: begin
            if (hit >= 0) begin
               ans.found = 1'b1;
               ans.mac   = gateway_table[hit].mac;
            end
         end
         vgc_pkg::CMD_LOOKUP_MAC: begin
            for (int k = 0; k < gateway_count; k++)
               if (gateway_table[k].mac == mac) ans.found = 1'b1;
         end
         default: ;
      endcase
      ans.count  = gateway_count[vgc_pkg::CountW-1:0];
      ans.active = gateway_count > 0;
      return ans;
   endfunction

   task automatic send_request(input logic [1:0] cmd, input logic [vgc_pkg::VlanW-1:0] vid,
                               input logic [vgc_pkg::MacW-1:0] mac);
      answer_type predicted;
      int         gap;
      start       <= 1'b1;
      req_command <= cmd;
      req_vlan_id <= vid;
      req_mac_in  <= mac;
      do @(posedge clock); while (busy);
      predicted = apply_table_command(cmd, vid, mac);
      pending_answers.push_back(predicted);
      requests_sent++;
      if (predicted.status == vgc_pkg::STATUS_TABLE_FULL) full_rejects++;
      if (predicted.found) lookup_hits++;
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, MaxGap);
      if (gap > 0) begin
         // junk on the request ports while start is low
         start       <= 1'b0;
         req_command <= 2'($urandom);
         req_vlan_id <= 12'($urandom);
         req_mac_in  <= {16'($urandom), $urandom};
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_edge_cases;
      sender_idle_pct = 0;
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd1, '0);
      send_request(vgc_pkg::CMD_LOOKUP_MAC, 12'd0, '0);
      send_request(vgc_pkg::CMD_REMOVE, 12'd5, '0);
      send_request(vgc_pkg::CMD_SET, 12'd0, 48'h0000_0000_0001);
      send_request(vgc_pkg::CMD_SET, 12'd4095, 48'h0000_0000_0002);
      send_request(vgc_pkg::CMD_REMOVE, 12'd0, '0);
      send_request(vgc_pkg::CMD_REMOVE, 12'd4095, '0);
      send_request(vgc_pkg::CMD_SET, 12'd1, '1);
      send_request(vgc_pkg::CMD_SET, 12'd4094, '0);
      send_request(vgc_pkg::CMD_SET, 12'd2048, 48'h8000_0000_0001);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd4094, '1);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd1, '0);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd0, '0);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd4095, '0);
      send_request(vgc_pkg::CMD_LOOKUP_MAC, 12'd1, '1);
      send_request(vgc_pkg::CMD_LOOKUP_MAC, 12'd4095, '0);
      send_request(vgc_pkg::CMD_LOOKUP_MAC, 12'd0, 48'h0000_0000_007b);
      send_request(vgc_pkg::CMD_SET, 12'd1, 48'h0123_4567_89ab);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd1, '0);
      send_request(vgc_pkg::CMD_REMOVE, 12'd300, '0);
      send_request(vgc_pkg::CMD_REMOVE, 12'd1, '0);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd2048, '0);
      send_request(vgc_pkg::CMD_REMOVE, 12'd2048, '0);
      send_request(vgc_pkg::CMD_REMOVE, 12'd4094, '0);
      send_request(vgc_pkg::CMD_LOOKUP_MAC, 12'd0, '0);
   endtask

   task automatic test_full_table;
      logic [vgc_pkg::VlanW-1:0] vid;
      sender_idle_pct = 65;
      for (int k = 0; k < Depth; k++) begin
         vid = 12'(k * 255 + 1);
         send_request(vgc_pkg::CMD_SET, vid, {16'($urandom), $urandom});
      end
      send_request(vgc_pkg::CMD_SET, 12'd4000, {16'($urandom), $urandom});
      send_request(vgc_pkg::CMD_SET, 12'd77, {16'($urandom), $urandom});
      // an update still succeeds on a full table, an invalid id still fails as invalid
      send_request(vgc_pkg::CMD_SET, 12'd1, 48'hfeed_0000_beef);
      send_request(vgc_pkg::CMD_SET, 12'd0, '0);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd1, '0);
      send_request(vgc_pkg::CMD_LOOKUP_MAC, 12'd0, 48'hfeed_0000_beef);
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd4000, '0);
      send_request(vgc_pkg::CMD_REMOVE, 12'd2041, '0);
      send_request(vgc_pkg::CMD_SET, 12'd3000, {16'($urandom), $urandom});
      send_request(vgc_pkg::CMD_LOOKUP_VLAN, 12'd3826, '0);
      while (gateway_count > 0)
         send_request(vgc_pkg::CMD_REMOVE,
                      gateway_table[$urandom_range(gateway_count - 1)].vlan,
                      {16'($urandom), $urandom});
   endtask

   task automatic test_random_churn(input int idle_pct, input int n_items);
      logic [vgc_pkg::VlanW-1:0] vid_pool[20];
      logic [vgc_pkg::MacW-1:0]  mac_pool[4];
      logic [1:0]                cmd;
      logic [vgc_pkg::VlanW-1:0] vid;
      logic [vgc_pkg::MacW-1:0]  mac;
      int                        set_w, rm_w, r;
      bit                        fill_bias;
      sender_idle_pct = idle_pct;
      foreach (vid_pool[k]) vid_pool[k] = 12'($urandom_range(1, 4094));
      foreach (mac_pool[k]) mac_pool[k] = {16'($urandom), $urandom};
      fill_bias = 1'b1;
      for (int n = 0; n < n_items; n++) begin
         // alternate between filling and draining so both full and empty are reached
         if (n % 40 == 39) fill_bias = !fill_bias;
         set_w = fill_bias ? 50 : 20;
         rm_w  = fill_bias ? 10 : 40;
         vid   = ($urandom_range(99) < 85) ? vid_pool[$urandom_range(19)]
                                           : 12'($urandom_range(0, 4095));
         mac   = ($urandom_range(99) < 30) ? mac_pool[$urandom_range(3)]
                                           : {16'($urandom), $urandom};
         r = $urandom_range(99);
         if ($urandom_range(99) < 10) begin
            cmd = 2'($urandom);
            vid = 12'($urandom);
            mac = {16'($urandom), $urandom};
         end else if (r < set_w) begin
            cmd = vgc_pkg::CMD_SET;
         end else if (r < set_w + rm_w) begin
            cmd = vgc_pkg::CMD_REMOVE;
            if (gateway_count > 0 && $urandom_range(99) < 60)
               vid = gateway_table[$urandom_range(gateway_count - 1)].vlan;
         end else if (r < set_w + rm_w + (100 - set_w - rm_w) / 2) begin
            cmd = vgc_pkg::CMD_LOOKUP_VLAN;
         end else begin
            cmd = vgc_pkg::CMD_LOOKUP_MAC;
            if (gateway_count > 0 && $urandom_range(1))
               mac = gateway_table[$urandom_range(gateway_count - 1)].mac;
         end
         send_request(cmd, vid, mac);
      end
   endtask

   // response check and watchdog
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               answers_checked++;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  mismatches++;
               end
               if (rsp_mac_out !== want.mac) begin
                  $error("mac_out: expected %h, got %h", want.mac, rsp_mac_out);
                  mismatches++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
                  mismatches++;
               end
               if (rsp_active !== want.active) begin
                  $error("active: expected %0d, got %0d", want.active, rsp_active);
                  mismatches++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WatchdogLimit) begin
            $display("timeout after %0d cycles without a handshake", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_full_table();
      test_random_churn(0, 250);
      test_random_churn(65, 250);
      test_random_churn(7, 250);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d requests, %0d responses compared", requests_sent, answers_checked);
      $display("%0d sets refused on a full table, %0d lookup hits", full_rejects, lookup_hits);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
